// ===== hw/rtl/vec3_pkg.sv =====
// ----------------------------------------------------------------------------
// vec3_pkg: shared types and codes of the 3D vector unit
// Operation codes, status codes and the control bundle that the top level
// hands to each component lane.
// ----------------------------------------------------------------------------
package vec3_pkg;

    typedef logic [2:0] mode_t;
    typedef logic [1:0] status_t;

    localparam mode_t MODE_ADD   = 3'd0;
    localparam mode_t MODE_SUB   = 3'd1;
    localparam mode_t MODE_DOT   = 3'd2;
    localparam mode_t MODE_CROSS = 3'd3;
    localparam mode_t MODE_NORM  = 3'd4;

    localparam status_t STAT_OK   = 2'd0;
    localparam status_t STAT_SAT  = 2'd1;
    localparam status_t STAT_ZERO = 2'd2;

    // Pipeline advance and the operation of the request entering the lanes.
    typedef struct packed {
        logic  en;
        mode_t mode;
    } lane_ctrl_t;

endpackage

// ===== hw/rtl/vec3_lane.sv =====
// ----------------------------------------------------------------------------
// vec3_lane: one component lane of the 3D vector unit
// Forms the two products and the sum or difference that one vector component
// needs, with the operands chosen by the operation, and registers them.
// ----------------------------------------------------------------------------
module vec3_lane #(
    parameter int W = 32
) (
    input  logic                   clk,
    input  vec3_pkg::lane_ctrl_t   ctrl,
    input  logic signed [W-1:0]    ai,
    input  logic signed [W-1:0]    bi,
    input  logic signed [W-1:0]    aj,
    input  logic signed [W-1:0]    bj,
    input  logic signed [W-1:0]    ak,
    input  logic signed [W-1:0]    bk,
    output logic signed [2*W-1:0]  p1,
    output logic signed [2*W-1:0]  p2,
    output logic signed [W:0]      asum
);
    import vec3_pkg::*;

    localparam int PW = 2 * W;

    logic signed [W-1:0]  op1a;
    logic signed [W-1:0]  op1b;
    logic signed [PW-1:0] p1_next;
    logic signed [PW-1:0] p2_next;
    logic signed [W:0]    asum_next;
    logic signed [PW-1:0] p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [W:0]    asum_reg;

    // Cross product uses the two other components; normalize squares A.
    always_comb
    begin
        case (ctrl.mode)
            MODE_CROSS:
            begin
                op1a = aj;
                op1b = bk;
            end
            MODE_NORM:
            begin
                op1a = ai;
                op1b = ai;
            end
            default:
            begin
                op1a = ai;
                op1b = bi;
            end
        endcase
    end

    assign p1_next   = PW'(op1a) * PW'(op1b);
    assign p2_next   = PW'(ak) * PW'(bj);
    assign asum_next = (ctrl.mode == MODE_SUB) ? ((W+1)'(ai) - (W+1)'(bi))
                                               : ((W+1)'(ai) + (W+1)'(bi));

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
        begin
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            asum_reg <= asum_next;
        end
    end

    assign p1   = p1_reg;
    assign p2   = p2_reg;
    assign asum = asum_reg;

endmodule

// ===== hw/rtl/vec3_sqrt.sv =====
// ----------------------------------------------------------------------------
// vec3_sqrt: pipelined integer square root
// Restoring digit-by-digit square root, one result bit per stage, giving the
// floor of the square root of a 2*W bit unsigned radicand after W stages.
// ----------------------------------------------------------------------------
module vec3_sqrt #(
    parameter int W = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [2*W-1:0]   radicand,
    output logic [W-1:0]     root
);
    localparam int RW = W + 3;

    logic [RW-1:0]  rem_reg  [W];
    logic [W-1:0]   root_reg [W];
    logic [2*W-1:0] rad_reg  [W];

    for (genvar g = 0; g < W; g++)
    begin : g_stage
        logic [RW-1:0]  rem_in;
        logic [W-1:0]   root_in;
        logic [2*W-1:0] rad_in;
        logic [RW-1:0]  cand;
        logic [RW-1:0]  trial;

        if (g == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[g-1];
            assign root_in = root_reg[g-1];
            assign rad_in  = rad_reg[g-1];
        end

        // The remainder stays below 2^(W+1), so its top two bits are zero.
        assign cand  = {rem_in[RW-3:0], rad_in[2*W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[g] <= {rad_in[2*W-3:0], 2'b00};
                if (cand >= trial)
                begin
                    rem_reg[g]  <= cand - trial;
                    root_reg[g] <= {root_in[W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[g]  <= cand;
                    root_reg[g] <= {root_in[W-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[W-1];

endmodule

// ===== hw/rtl/vec3_div.sv =====
// ----------------------------------------------------------------------------
// vec3_div: pipelined divider for one normalized component
// Computes floor(mag * 2^F / divisor) by restoring long division, one
// quotient bit per stage, for a divisor not below mag.
// ----------------------------------------------------------------------------
module vec3_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [W-1:0]  mag,
    input  logic [W-1:0]  divisor,
    output logic [F:0]    quot
);
    logic [W-1:0] rem_reg [F+1];
    logic [F:0]   q_reg   [F+1];
    logic [W-1:0] dv_reg  [F+1];

    for (genvar g = 0; g <= F; g++)
    begin : g_stage
        logic [W-1:0] rem_in;
        logic [F:0]   q_in;
        logic [W-1:0] dv_in;
        logic         nbit;
        logic [W:0]   cand;
        logic [W:0]   diff;

        // The quotient fits in F+1 bits, so the division starts with the
        // numerator shifted down by F+1, which is already below the divisor.
        if (g == 0)
        begin : g_first
            assign rem_in = {1'b0, mag[W-1:1]};
            assign q_in   = '0;
            assign dv_in  = divisor;
            assign nbit   = mag[0];
        end
        else
        begin : g_next
            assign rem_in = rem_reg[g-1];
            assign q_in   = q_reg[g-1];
            assign dv_in  = dv_reg[g-1];
            assign nbit   = 1'b0;
        end

        assign cand = {rem_in, nbit};
        assign diff = cand - {1'b0, dv_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[g] <= dv_in;
                if (cand >= {1'b0, dv_in})
                begin
                    rem_reg[g] <= diff[W-1:0];
                    q_reg[g]   <= {q_in[F-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[g] <= cand[W-1:0];
                    q_reg[g]   <= {q_in[F-1:0], 1'b0};
                end
            end
        end
    end

    assign quot = q_reg[F];

endmodule

// ===== hw/rtl/vector3_alu.sv =====
// ----------------------------------------------------------------------------
// vector3_alu: pipelined 3D vector unit on signed fixed-point components
// Add, subtract, dot product, cross product and normalize, with saturation.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one request per cycle unless stalled: s_tuser
// carries the operation and s_tdata the six components of A and B. The master
// channel returns exactly one result per request, in order: s_tdata-style
// packing of rx, ry, rz and scalar on m_tdata, and the status code on m_tuser.
// Every request, whatever its operation, goes through the same fixed
// pipeline, so results stay in order. Its length is set by the square root
// unit, one root bit per stage over COMPONENT_WIDTH + 1 stages, followed by
// the divider, one quotient bit per stage. Throughput is one request per
// cycle while the output does not stall.
// The whole pipeline advances together. While a result sits in the output
// register and the receiver holds m_tready low, s_tready is low and every
// stage holds; otherwise a request is taken each cycle, also while the
// output register holds a result that is being taken in the same cycle.
// Reset clears every valid bit, so the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
module vector3_alu #(
    parameter int COMPONENT_WIDTH = 32,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // ax, ay, az, bx, by, bz from the lowest bit up, zero padded to bytes
    input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    // mode
    input  vec3_pkg::mode_t           s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // rx, ry, rz, scalar from the lowest bit up, zero padded to bytes
    output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_tdata,
    // status
    output vec3_pkg::status_t         m_tuser
);
    import vec3_pkg::*;

    localparam int W      = COMPONENT_WIDTH;
    localparam int F      = FRACTION_BITS;
    localparam int XW     = 2 * W + 3;
    localparam int D      = W + F + 2;
    localparam int DW_OUT = ((4 * W + 7) / 8) * 8;

    typedef struct packed {
        mode_t              mode;
        logic               zero;
        logic               satf;
        logic [2:0]         asign;
        logic [2:0][W-1:0]  r;
        logic [W-1:0]       sc;
    } res_t;

    // Round half up from 2F to F fraction bits.
    function automatic logic signed [XW-1:0] round_fn(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] t;
        t = x + (XW'(1) <<< (F - 1));
        return t >>> F;
    endfunction

    // Clamp to the component range; the top bit of the result flags a clamp.
    function automatic logic [W:0] sat_fn(input logic signed [XW-1:0] y);
        logic [XW-W:0] hi;
        hi = y[XW-1:W-1];
        if ((&hi) || (~|hi))
            return {1'b0, y[W-1:0]};
        else if (y[XW-1])
            return {1'b1, 1'b1, {(W-1){1'b0}}};
        else
            return {1'b1, 1'b0, {(W-1){1'b1}}};
    endfunction

    logic                    en;
    lane_ctrl_t              ctrl;
    logic signed [W-1:0]     a_in [3];
    logic signed [W-1:0]     b_in [3];

    // Stage 1: lane products.
    logic                    valid1_reg;
    mode_t                   mode1_reg;
    logic signed [W-1:0]     a1_reg [3];
    logic signed [2*W-1:0]   p1 [3];
    logic signed [2*W-1:0]   p2 [3];
    logic signed [W:0]       asum [3];

    // Stage 2: cross differences and the merged sum of products.
    logic                    valid2_reg;
    mode_t                   mode2_reg;
    logic signed [W-1:0]     a2_reg [3];
    logic signed [2*W:0]     d2_reg [3];
    logic signed [2*W+1:0]   sum2_reg;
    logic signed [W:0]       as2_reg [3];

    res_t                    res_next;
    logic [2:0][W-1:0]       mag_next;

    // Delay line that runs beside the square root and divider pipelines.
    res_t                    dl_reg [D];
    logic [D-1:0]            dl_valid_reg;
    logic [2:0][W-1:0]       mag_dl_reg [W+1];

    // The sum of three squares fits in 2W bits; its root therefore fits in W bits,
    // so the top root bit is always zero.
    logic [W:0]              root;
    logic [F:0]              quot [3];

    logic [2:0][W-1:0]       out_r_next;
    status_t                 status_next;
    logic                    out_valid_reg;
    logic [2:0][W-1:0]       out_r_reg;
    logic [W-1:0]            out_sc_reg;
    status_t                 status_reg;

    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign ctrl.en   = en;
    assign ctrl.mode = s_tuser;

    for (genvar i = 0; i < 3; i++)
    begin : g_unpack
        assign a_in[i] = s_tdata[i*W +: W];
        assign b_in[i] = s_tdata[(i+3)*W +: W];
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        vec3_lane #(
            .W(W)
        ) u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .ai   (a_in[i]),
            .bi   (b_in[i]),
            .aj   (a_in[(i+1)%3]),
            .bj   (b_in[(i+1)%3]),
            .ak   (a_in[(i+2)%3]),
            .bk   (b_in[(i+2)%3]),
            .p1   (p1[i]),
            .p2   (p2[i]),
            .asum (asum[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            dl_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg    <= s_tvalid;
            valid2_reg    <= valid1_reg;
            dl_valid_reg  <= {dl_valid_reg[D-2:0], valid2_reg};
            out_valid_reg <= dl_valid_reg[D-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= s_tuser;
            mode2_reg <= mode1_reg;
            sum2_reg  <= (2*W+2)'(p1[0]) + (2*W+2)'(p1[1]) + (2*W+2)'(p1[2]);
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i]  <= a_in[i];
                a2_reg[i]  <= a1_reg[i];
                d2_reg[i]  <= (2*W+1)'(p1[i]) - (2*W+1)'(p2[i]);
                as2_reg[i] <= asum[i];
            end
            dl_reg[0]     <= res_next;
            mag_dl_reg[0] <= mag_next;
            for (int t = 1; t < D; t++)
                dl_reg[t] <= dl_reg[t-1];
            for (int t = 1; t < W + 1; t++)
                mag_dl_reg[t] <= mag_dl_reg[t-1];
            out_r_reg  <= out_r_next;
            out_sc_reg <= dl_reg[D-1].sc;
            status_reg <= status_next;
        end
    end

    // Round, saturate and pick the results of the short operations.
    always_comb
    begin
        logic [W:0] s;
        res_next       = '0;
        res_next.mode  = mode2_reg;
        res_next.zero  = (sum2_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            res_next.asign[i] = a2_reg[i][W-1];
            mag_next[i]       = a2_reg[i][W-1] ? (W'(0) - W'(a2_reg[i])) : W'(a2_reg[i]);
        end
        unique case (mode2_reg)
            MODE_ADD, MODE_SUB:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s                = sat_fn(XW'(as2_reg[i]));
                    res_next.r[i]    = s[W-1:0];
                    res_next.satf    = res_next.satf | s[W];
                end
            end
            MODE_DOT:
            begin
                s             = sat_fn(round_fn(XW'(sum2_reg)));
                res_next.sc   = s[W-1:0];
                res_next.satf = s[W];
            end
            MODE_CROSS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s                = sat_fn(round_fn(XW'(d2_reg[i])));
                    res_next.r[i]    = s[W-1:0];
                    res_next.satf    = res_next.satf | s[W];
                end
            end
            default:
            begin
                s = '0;
            end
        endcase
    end

    vec3_sqrt #(
        .W(W + 1)
    ) u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum2_reg),
        .root     (root)
    );

    for (genvar i = 0; i < 3; i++)
    begin : g_div
        vec3_div #(
            .W(W),
            .F(F)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .mag     (mag_dl_reg[W][i]),
            .divisor (root[W-1:0]),
            .quot    (quot[i])
        );
    end

    // Merge: normalized components come from the dividers, the rest from
    // the delay line.
    always_comb
    begin
        logic                 satf;
        logic                 zero;
        logic signed [XW-1:0] qv;
        logic [W:0]           s;
        out_r_next = dl_reg[D-1].r;
        satf       = dl_reg[D-1].satf;
        zero       = 1'b0;
        qv         = '0;
        s          = '0;
        if (dl_reg[D-1].mode == MODE_NORM)
        begin
            if (dl_reg[D-1].zero)
            begin
                zero       = 1'b1;
                satf       = 1'b0;
                out_r_next = '0;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    qv = XW'(quot[i]);
                    if (dl_reg[D-1].asign[i])
                        qv = -qv;
                    s             = sat_fn(qv);
                    out_r_next[i] = s[W-1:0];
                    satf          = satf | s[W];
                end
            end
        end
        if (zero)
            status_next = STAT_ZERO;
        else if (satf)
            status_next = STAT_SAT;
        else
            status_next = STAT_OK;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DW_OUT'({out_sc_reg, out_r_reg[2], out_r_reg[1], out_r_reg[0]});
    assign m_tuser  = status_reg;

`ifndef SYNTHESIS
    // A zero-length normalize returns all value fields zero.
    a_zero_len_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == STAT_ZERO)) |-> (m_tdata == '0))
        else $error("zero-length status with nonzero result");

    // A stalled result stops the whole pipeline, so no request is taken.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("request taken while output stalled");

    // A stalled result is not overwritten by the next one.
    a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");
`endif

endmodule
